>>> sv/amd_pkg.sv
// shared types and constants for the acceleration magnitude motion detector
package amd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 31;
    localparam int SUM_W      = 32;
    localparam int RAD_W      = 36;
    localparam int MAG_W      = 18;
    localparam int REM_W      = 20;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int ROOT_STEPS = 18;
    localparam int CNT_W      = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 1'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd250;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_START,
        ST_ROOT,
        ST_DONE
    } amd_state_t;

endpackage

>>> sv/amd_if.sv
// valid/ready channel interfaces for samples and results

interface amd_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [amd_pkg::SAMPLE_W-1:0]   accel_x;
    logic signed [amd_pkg::SAMPLE_W-1:0]   accel_y;
    logic signed [amd_pkg::SAMPLE_W-1:0]   accel_z;
    logic                                  read_ok;

    modport source (output valid, accel_x, accel_y, accel_z, read_ok, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, read_ok, output ready);
endinterface

interface amd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          moved;
    logic [amd_pkg::MAG_W-1:0]     magnitude;

    modport source (output valid, moved, magnitude, input ready);
    modport sink   (input valid, moved, magnitude, output ready);
endinterface

>>> sv/amd_square_lane.sv
// one axis lane: absolute value and registered square
module amd_square_lane
(
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [amd_pkg::SAMPLE_W-1:0] sample,
    output logic [amd_pkg::SQ_W-1:0]            square
);

    logic [amd_pkg::SAMPLE_W-1:0]   mag_abs;
    logic [2*amd_pkg::SAMPLE_W-1:0] product;
    logic [amd_pkg::SQ_W-1:0]       square_reg;

    // most negative code wraps to 0x8000, which is the right unsigned value
    assign mag_abs = sample[amd_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
    assign product = mag_abs * mag_abs;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            square_reg <= product[amd_pkg::SQ_W-1:0];
        end
    end

    assign square = square_reg;

endmodule

>>> sv/amd_merge.sv
// merging stage: registered sum of the three lane squares
module amd_merge
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [amd_pkg::SQ_W-1:0]    square_x,
    input  logic [amd_pkg::SQ_W-1:0]    square_y,
    input  logic [amd_pkg::SQ_W-1:0]    square_z,
    output logic [amd_pkg::SUM_W-1:0]   sum
);

    logic [amd_pkg::SUM_W-1:0] sum_reg;
    logic [amd_pkg::SUM_W-1:0] sum_next;

    assign sum_next = {1'b0, square_x} + {1'b0, square_y} + {1'b0, square_z};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

>>> sv/amd_isqrt.sv
// iterative floor square root, one result bit per cycle
module amd_isqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [amd_pkg::RAD_W-1:0]   radicand,
    output logic                        done,
    output logic [amd_pkg::MAG_W-1:0]   root
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [amd_pkg::CNT_W-1:0]      cnt_reg;
    logic [amd_pkg::RAD_W-1:0]      rad_reg;
    logic [amd_pkg::REM_W-1:0]      rem_reg;
    logic [amd_pkg::MAG_W-1:0]      root_reg;

    logic [amd_pkg::REM_W+1:0]      rem_shift;
    logic [amd_pkg::REM_W+1:0]      trial;
    logic [amd_pkg::REM_W+1:0]      rem_diff;
    logic                           take;

    assign rem_shift = {rem_reg, rad_reg[amd_pkg::RAD_W-1 -: 2]};
    assign trial     = {{(amd_pkg::REM_W-amd_pkg::MAG_W){1'b0}}, root_reg, 2'b01};
    assign take      = (rem_shift >= trial);
    assign rem_diff  = rem_shift - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == amd_pkg::CNT_W'(amd_pkg::ROOT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[amd_pkg::RAD_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= rem_diff[amd_pkg::REM_W-1:0];
                root_reg <= {root_reg[amd_pkg::MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[amd_pkg::REM_W-1:0];
                root_reg <= {root_reg[amd_pkg::MAG_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/accel_magnitude_motion_detector_unit.sv
// top level of the acceleration magnitude motion detector
//
// Takes one three-axis sample per transfer on the sample channel and returns one
// result per sample: the magnitude sqrt(x^2+y^2+z^2) in unsigned Q16.2 (floor of
// sqrt(16*(x^2+y^2+z^2))) and a moved flag, set when the magnitude differs from the
// last stored one by more than 4*move_threshold. Three lanes square the axes in
// parallel, a merging stage adds them, and a shared iterative square root unit
// produces one root bit per cycle. One sample is in flight at a time; from its
// transfer a sample passes the lane registers, the merge register, a root start
// step, the root iterations for the 18-bit root until done is seen, and a result
// step that waits for a free result register, before the engine takes the next
// one. The result sits in an output register, so a new sample is taken while the
// last result waits. The first valid sample after reset stores its magnitude and
// reports not moved. With sensor_present low or read_ok low the result is zero
// and the stored magnitude is left alone. Configuration (index 0 sensor_present,
// index 1 move_threshold, reset 0 and 250) must be written only while no sample
// is in flight; the block itself does not enforce this.
module accel_magnitude_motion_detector_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [amd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [amd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    amd_sample_if.sink                          sample,
    amd_result_if.source                        result
);

    // configuration registers
    logic                           sensor_present_reg;
    logic [amd_pkg::THR_W-1:0]      move_threshold_reg;

    // engine control
    amd_pkg::amd_state_t            state_reg;
    amd_pkg::amd_state_t            state_next;
    logic                           use_reg;

    // stored magnitude from the last valid sample
    logic [amd_pkg::MAG_W-1:0]      prev_mag_reg;
    logic                           have_prev_reg;

    // output register
    logic                           out_valid_reg;
    logic                           out_moved_reg;
    logic [amd_pkg::MAG_W-1:0]      out_mag_reg;

    // datapath
    logic [amd_pkg::SQ_W-1:0]       square_x;
    logic [amd_pkg::SQ_W-1:0]       square_y;
    logic [amd_pkg::SQ_W-1:0]       square_z;
    logic [amd_pkg::SUM_W-1:0]      sum;
    logic                           root_done;
    logic [amd_pkg::MAG_W-1:0]      root;
    logic [amd_pkg::MAG_W-1:0]      delta;
    logic [amd_pkg::MAG_W-1:0]      thr_scaled;
    logic                           moved_now;

    // control outputs
    logic                           in_xfer;
    logic                           merge_load;
    logic                           root_start;
    logic                           out_load;
    logic                           out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_present_reg <= 1'b0;
            move_threshold_reg <= amd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                amd_pkg::REG_SENSOR_PRESENT: sensor_present_reg <= cfg_wdata[0];
                amd_pkg::REG_MOVE_THRESHOLD: move_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // three axis lanes side by side
    amd_square_lane u_lane_x
    (
        .clk    (clk),
        .load   (in_xfer),
        .sample (sample.accel_x),
        .square (square_x)
    );

    amd_square_lane u_lane_y
    (
        .clk    (clk),
        .load   (in_xfer),
        .sample (sample.accel_y),
        .square (square_y)
    );

    amd_square_lane u_lane_z
    (
        .clk    (clk),
        .load   (in_xfer),
        .sample (sample.accel_z),
        .square (square_z)
    );

    // merge the lane results into the sum of squares
    amd_merge u_merge
    (
        .clk      (clk),
        .load     (merge_load),
        .square_x (square_x),
        .square_y (square_y),
        .square_z (square_z),
        .sum      (sum)
    );

    // Q16.2 scaling: root of the sum times 16
    amd_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand ({sum, 4'b0000}),
        .done     (root_done),
        .root     (root)
    );

    // change against the stored magnitude
    assign delta      = (root >= prev_mag_reg) ? (root - prev_mag_reg) : (prev_mag_reg - root);
    assign thr_scaled = {move_threshold_reg, 2'b00};
    assign moved_now  = have_prev_reg && (delta > thr_scaled);

    assign out_free = !out_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            amd_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = amd_pkg::ST_SUM;
                end
            end
            amd_pkg::ST_SUM:   state_next = amd_pkg::ST_START;
            amd_pkg::ST_START: state_next = amd_pkg::ST_ROOT;
            amd_pkg::ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = amd_pkg::ST_DONE;
                end
            end
            amd_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = amd_pkg::ST_IDLE;
                end
            end
            default: state_next = amd_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        sample.ready = 1'b0;
        merge_load   = 1'b0;
        root_start   = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            amd_pkg::ST_IDLE:  sample.ready = 1'b1;
            amd_pkg::ST_SUM:   merge_load   = 1'b1;
            amd_pkg::ST_START: root_start   = 1'b1;
            amd_pkg::ST_ROOT:  ;
            amd_pkg::ST_DONE:  out_load     = out_free;
            default: ;
        endcase
    end

    assign in_xfer = sample.valid && sample.ready;

    // engine state, sample qualifier and stored magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= amd_pkg::ST_IDLE;
            use_reg       <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_mag_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                use_reg <= sensor_present_reg && sample.read_ok;
            end
            // skipped samples leave the stored magnitude alone
            if (out_load && use_reg)
            begin
                prev_mag_reg  <= root;
                have_prev_reg <= 1'b1;
            end
        end
    end

    // output register, drained by a result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_moved_reg <= use_reg && moved_now;
            out_mag_reg   <= use_reg ? root : '0;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.moved     = out_moved_reg;
    assign result.magnitude = out_mag_reg;

endmodule
